// ===== rtl/ksl_pkg.sv =====
// Package for the keyed slot table: field widths, operation and status codes,
// and the compare result type shared by the compare unit and the top level.
// Depends on nothing.
`default_nettype none

package ksl_pkg;

    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 56;
    localparam int INFO_W   = 32;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;
    localparam int ENTRY_W  = KEY_W + INFO_W;

    // A range select reports at most this many matching entries.
    localparam int RESULT_LIMIT = 16;
    localparam int MATCH_W      = $clog2(RESULT_LIMIT + 1);

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_INSERT    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL_RANGE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SEL_RANGE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREE      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 3'd5;

    typedef struct packed {
        logic eq;        // entry key equals the lower bound
        logic in_range;  // lower bound <= entry key <= upper bound
    } cmp_t;

endpackage

`default_nettype wire

// ===== rtl/ksl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// The read data holds while the read enable is low. No dependencies.
`default_nettype none

module ksl_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ksl_cmp.sv =====
// Shared key compare unit: equality against the lower bound and an inclusive
// range test, applied to one stored entry per cycle. Uses ksl_pkg.
`default_nettype none

module ksl_cmp (
    input  wire logic [ksl_pkg::KEY_W-1:0] entry_key,
    input  wire logic [ksl_pkg::KEY_W-1:0] lo,
    input  wire logic [ksl_pkg::KEY_W-1:0] hi,
    output ksl_pkg::cmp_t                  result
);

    always_comb
    begin
        result.eq       = (entry_key == lo);
        result.in_range = (entry_key >= lo) && (entry_key <= hi);
    end

endmodule

`default_nettype wire

// ===== rtl/keyed_slot_table_unit.sv =====
// Keyed slot table: a table of SLOTS entries with insert, remove, range delete,
// range select and read. Uses ksl_pkg, ksl_ram and ksl_cmp.
//
// Usage. A request enters on in_valid/in_stall and carries func, key,
// key_upper, info_handle and slot_index. It is taken at a rising edge with
// in_valid high and in_stall low. Results leave on out_valid/out_stall, one
// per accepted edge, with last set on the final result of a request.
// Insert, range delete and range select walk the table one slot per cycle
// through the single read port of the entry RAM and the shared compare unit;
// in_stall stays high until the final result of a request is loaded into the
// output register, so no new request is taken before then. A read fetches
// its entry when taken. Unknown function codes are taken and dropped without
// a result. A range select emits up to 16 results; each match is held until
// the next one is found so that last can be set correctly, and the walk pauses
// while a match must push out the held one and the output is full and stalled.
// A stalled result holds its value, and a new result is loaded only when the
// output register is empty or being taken in the same cycle.
// Reset clears the busy mark of every slot, so the table starts empty; the
// key and handle RAM is not cleared, since a free slot is never reported.
`default_nettype none

module keyed_slot_table_unit #(
    parameter int SLOTS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [ksl_pkg::FUNC_W-1:0]       func,
    input  wire logic [ksl_pkg::KEY_W-1:0]        key,
    input  wire logic [ksl_pkg::KEY_W-1:0]        key_upper,
    input  wire logic [ksl_pkg::INFO_W-1:0]       info_handle,
    input  wire logic [ksl_pkg::SLOT_W-1:0]       slot_index,

    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [ksl_pkg::STATUS_W-1:0]     status,
    output logic      [ksl_pkg::SLOT_W-1:0]       slot,
    output logic      [ksl_pkg::KEY_W-1:0]        found_key,
    output logic      [ksl_pkg::INFO_W-1:0]       found_info,
    output logic      [ksl_pkg::COUNT_W-1:0]      removed_count,
    output logic                                  last
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FIN    = 4'b0100,
        S_SINGLE = 4'b1000
    } state_t;

    // Control state.
    state_t                          state_reg, state_next;
    logic                            busy_reg [SLOTS];
    logic                            busy_next [SLOTS];
    logic [CW-1:0]                   addr_cnt_reg, addr_cnt_next;
    logic                            rd_pend_reg, rd_pend_next;
    logic                            free_found_reg, free_found_next;
    logic                            dup_found_reg, dup_found_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [ksl_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [ksl_pkg::MATCH_W-1:0]     match_n_reg, match_n_next;
    logic                            out_valid_reg, out_valid_next;

    // Request and working payload.
    logic [ksl_pkg::FUNC_W-1:0]      func_reg, func_next;
    logic [ksl_pkg::KEY_W-1:0]       lo_reg, lo_next;
    logic [ksl_pkg::KEY_W-1:0]       hi_reg, hi_next;
    logic [ksl_pkg::INFO_W-1:0]      info_reg, info_next;
    logic [ksl_pkg::SLOT_W-1:0]      idx_reg, idx_next;
    logic [AW-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]                   free_slot_reg, free_slot_next;
    logic [AW-1:0]                   dup_slot_reg, dup_slot_next;
    logic [AW-1:0]                   pend_slot_reg, pend_slot_next;
    logic [ksl_pkg::KEY_W-1:0]       pend_key_reg, pend_key_next;
    logic [ksl_pkg::INFO_W-1:0]      pend_info_reg, pend_info_next;

    // Output register payload.
    logic [ksl_pkg::STATUS_W-1:0]    status_reg;
    logic [ksl_pkg::SLOT_W-1:0]      slot_reg;
    logic [ksl_pkg::KEY_W-1:0]       found_key_reg;
    logic [ksl_pkg::INFO_W-1:0]      found_info_reg;
    logic [ksl_pkg::COUNT_W-1:0]     removed_count_reg;
    logic                            last_reg;

    // Values loaded into the output register.
    logic                            out_load;
    logic [ksl_pkg::STATUS_W-1:0]    ld_status;
    logic [ksl_pkg::SLOT_W-1:0]      ld_slot;
    logic [ksl_pkg::KEY_W-1:0]       ld_key;
    logic [ksl_pkg::INFO_W-1:0]      ld_info;
    logic [ksl_pkg::COUNT_W-1:0]     ld_count;
    logic                            ld_last;

    // Entry RAM ports.
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [ksl_pkg::ENTRY_W-1:0]     ram_wdata;
    logic                            ram_re;
    logic [AW-1:0]                   ram_raddr;
    logic [ksl_pkg::ENTRY_W-1:0]     ram_rdata;
    logic [ksl_pkg::KEY_W-1:0]       rd_key;
    logic [ksl_pkg::INFO_W-1:0]      rd_info;

    ksl_pkg::cmp_t                   cmp;
    logic                            out_free;
    logic                            entry_busy;
    logic                            hit;
    logic                            scan_hold;
    logic                            adv;
    logic                            limit_hit;
    logic                            scan_end;
    logic                            idx_oob;
    logic                            idx_busy;
    logic [ksl_pkg::KEY_W-1:0]       in_lo;
    logic [ksl_pkg::KEY_W-1:0]       in_hi;

    ksl_ram #(
        .WIDTH (ksl_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[ksl_pkg::ENTRY_W-1 -: ksl_pkg::KEY_W];
    assign rd_info = ram_rdata[ksl_pkg::INFO_W-1:0];

    ksl_cmp u_cmp (
        .entry_key (rd_key),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .result    (cmp)
    );

    // The output register can take a new result when it is empty or drains now.
    assign out_free = !out_valid_reg || !out_stall;

    // Slot currently in the compare stage.
    assign entry_busy = busy_reg[cmp_idx_reg];
    assign hit        = entry_busy && cmp.in_range;

    // A select match that must push the held match out waits for the output.
    assign scan_hold = rd_pend_reg && (func_reg == ksl_pkg::FUNC_SEL_RANGE) && hit
                       && pend_valid_reg && !out_free;
    assign adv       = !scan_hold;
    assign limit_hit = (match_n_reg == ksl_pkg::MATCH_W'(ksl_pkg::RESULT_LIMIT - 1));
    assign scan_end  = (addr_cnt_reg == CW'(SLOTS));

    assign idx_oob  = ({1'b0, idx_reg} >= ksl_pkg::COUNT_W'(SLOTS));
    assign idx_busy = !idx_oob && busy_reg[AW'(idx_reg)];

    // Range bounds are put in order; insert keeps its key as given.
    assign in_lo = (func != ksl_pkg::FUNC_INSERT && key > key_upper) ? key_upper : key;
    assign in_hi = (key > key_upper) ? key : key_upper;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        addr_cnt_next   = addr_cnt_reg;
        rd_pend_next    = rd_pend_reg;
        free_found_next = free_found_reg;
        dup_found_next  = dup_found_reg;
        pend_valid_next = pend_valid_reg;
        count_next      = count_reg;
        match_n_next    = match_n_reg;
        func_next       = func_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        info_next       = info_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        free_slot_next  = free_slot_reg;
        dup_slot_next   = dup_slot_reg;
        pend_slot_next  = pend_slot_reg;
        pend_key_next   = pend_key_reg;
        pend_info_next  = pend_info_reg;

        ram_we    = 1'b0;
        ram_waddr = free_slot_reg;
        ram_wdata = {lo_reg, info_reg};
        ram_re    = 1'b0;
        ram_raddr = addr_cnt_reg[AW-1:0];

        out_load  = 1'b0;
        ld_status = ksl_pkg::ST_OK;
        ld_slot   = '0;
        ld_key    = '0;
        ld_info   = '0;
        ld_count  = '0;
        ld_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next       = func;
                    lo_next         = in_lo;
                    hi_next         = in_hi;
                    info_next       = info_handle;
                    idx_next        = slot_index;
                    addr_cnt_next   = '0;
                    rd_pend_next    = 1'b0;
                    free_found_next = 1'b0;
                    dup_found_next  = 1'b0;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    match_n_next    = '0;
                    if (func == ksl_pkg::FUNC_INSERT || func == ksl_pkg::FUNC_DEL_RANGE
                        || func == ksl_pkg::FUNC_SEL_RANGE)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (func == ksl_pkg::FUNC_REMOVE || func == ksl_pkg::FUNC_READ)
                    begin
                        // For a read, fetch the entry now; its data waits in the RAM register.
                        ram_re     = (func == ksl_pkg::FUNC_READ);
                        ram_raddr  = AW'(slot_index);
                        state_next = S_SINGLE;
                    end
                end
            end

            S_SCAN:
            begin
                // Compare stage: one slot per cycle from the RAM register while not held.
                if (rd_pend_reg && adv)
                begin
                    if (func_reg == ksl_pkg::FUNC_INSERT)
                    begin
                        if (!entry_busy && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_slot_next  = cmp_idx_reg;
                        end
                        if (entry_busy && cmp.eq && !dup_found_reg)
                        begin
                            dup_found_next = 1'b1;
                            dup_slot_next  = cmp_idx_reg;
                        end
                    end
                    else if (func_reg == ksl_pkg::FUNC_DEL_RANGE)
                    begin
                        if (hit)
                        begin
                            busy_next[cmp_idx_reg] = 1'b0;
                            count_next             = count_reg + 1'b1;
                        end
                    end
                    else if (hit)
                    begin
                        // Range select: emit the held match, hold this one.
                        if (pend_valid_reg)
                        begin
                            out_load  = 1'b1;
                            ld_slot   = ksl_pkg::SLOT_W'(pend_slot_reg);
                            ld_key    = pend_key_reg;
                            ld_info   = pend_info_reg;
                            ld_last   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = cmp_idx_reg;
                        pend_key_next   = rd_key;
                        pend_info_next  = rd_info;
                        match_n_next    = match_n_reg + 1'b1;
                    end
                end

                // Read-issue stage.
                if (rd_pend_reg && adv && func_reg == ksl_pkg::FUNC_SEL_RANGE && hit
                    && limit_hit)
                begin
                    rd_pend_next = 1'b0;
                    state_next   = S_FIN;
                end
                else if (adv)
                begin
                    if (!scan_end)
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = addr_cnt_reg[AW-1:0];
                        cmp_idx_next  = addr_cnt_reg[AW-1:0];
                        addr_cnt_next = addr_cnt_reg + 1'b1;
                        rd_pend_next  = 1'b1;
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                        state_next   = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (func_reg == ksl_pkg::FUNC_INSERT)
                    begin
                        if (!free_found_reg)
                        begin
                            ld_status = ksl_pkg::ST_FULL;
                        end
                        else if (dup_found_reg)
                        begin
                            ld_status = ksl_pkg::ST_DUPLICATE;
                            ld_slot   = ksl_pkg::SLOT_W'(dup_slot_reg);
                        end
                        else
                        begin
                            ram_we                   = 1'b1;
                            busy_next[free_slot_reg] = 1'b1;
                            ld_slot                  = ksl_pkg::SLOT_W'(free_slot_reg);
                        end
                    end
                    else if (func_reg == ksl_pkg::FUNC_DEL_RANGE)
                    begin
                        ld_status = (count_reg != '0) ? ksl_pkg::ST_OK : ksl_pkg::ST_NO_MATCH;
                        ld_count  = count_reg;
                    end
                    else if (pend_valid_reg)
                    begin
                        ld_slot = ksl_pkg::SLOT_W'(pend_slot_reg);
                        ld_key  = pend_key_reg;
                        ld_info = pend_info_reg;
                    end
                    else
                    begin
                        ld_status = ksl_pkg::ST_NO_MATCH;
                    end
                end
            end

            S_SINGLE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    ld_slot    = idx_reg;
                    if (idx_oob)
                    begin
                        ld_status = ksl_pkg::ST_BAD_INDEX;
                    end
                    else if (!idx_busy)
                    begin
                        ld_status = ksl_pkg::ST_FREE;
                    end
                    else if (func_reg == ksl_pkg::FUNC_REMOVE)
                    begin
                        busy_next[AW'(idx_reg)] = 1'b0;
                    end
                    else
                    begin
                        ld_key  = rd_key;
                        ld_info = rd_info;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            addr_cnt_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            dup_found_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            match_n_reg    <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                busy_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            addr_cnt_reg   <= addr_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            free_found_reg <= free_found_next;
            dup_found_reg  <= dup_found_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            match_n_reg    <= match_n_next;
            out_valid_reg  <= out_valid_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        info_reg      <= info_next;
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        free_slot_reg <= free_slot_next;
        dup_slot_reg  <= dup_slot_next;
        pend_slot_reg <= pend_slot_next;
        pend_key_reg  <= pend_key_next;
        pend_info_reg <= pend_info_next;
        if (out_load)
        begin
            status_reg        <= ld_status;
            slot_reg          <= ld_slot;
            found_key_reg     <= ld_key;
            found_info_reg    <= ld_info;
            removed_count_reg <= ld_count;
            last_reg          <= ld_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign found_key     = found_key_reg;
    assign found_info    = found_info_reg;
    assign removed_count = removed_count_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for keyed_slot_table_unit: directed and random table requests
// are checked against a behavioral copy of the slot table kept in this file.
// Depends on ksl_pkg and the keyed_slot_table_unit RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOTS        = 16;
    localparam int TOTAL_ITEMS  = 460;
    localparam int POOL_SIZE    = 24;
    // Window of accepted requests in which neither side idles or stalls.
    localparam int CALM_FROM    = 200;
    localparam int CALM_TO      = 320;
    localparam int IDLE_PCT     = 23;

    localparam logic [ksl_pkg::KEY_W-1:0]  KEY_MAX  = '1;
    localparam logic [ksl_pkg::INFO_W-1:0] INFO_MAX = '1;

    // One request as presented on the input channel.
    typedef struct {
        logic [ksl_pkg::FUNC_W-1:0] func;
        logic [ksl_pkg::KEY_W-1:0]  key;
        logic [ksl_pkg::KEY_W-1:0]  key_upper;
        logic [ksl_pkg::INFO_W-1:0] info;
        logic [ksl_pkg::SLOT_W-1:0] index;
    } table_req_t;

    // One result as it leaves on the output channel.
    typedef struct {
        logic [ksl_pkg::STATUS_W-1:0] status;
        logic [ksl_pkg::SLOT_W-1:0]   slot;
        logic [ksl_pkg::KEY_W-1:0]    found_key;
        logic [ksl_pkg::INFO_W-1:0]   found_info;
        logic [ksl_pkg::COUNT_W-1:0]  removed_count;
        logic                         last;
    } table_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                         in_valid    = 1'b0;
    logic                         in_stall;
    logic [ksl_pkg::FUNC_W-1:0]   func        = '0;
    logic [ksl_pkg::KEY_W-1:0]    key         = '0;
    logic [ksl_pkg::KEY_W-1:0]    key_upper   = '0;
    logic [ksl_pkg::INFO_W-1:0]   info_handle = '0;
    logic [ksl_pkg::SLOT_W-1:0]   slot_index  = '0;

    logic                         out_valid;
    logic                         out_stall   = 1'b0;
    logic [ksl_pkg::STATUS_W-1:0] status;
    logic [ksl_pkg::SLOT_W-1:0]   slot;
    logic [ksl_pkg::KEY_W-1:0]    found_key;
    logic [ksl_pkg::INFO_W-1:0]   found_info;
    logic [ksl_pkg::COUNT_W-1:0]  removed_count;
    logic                         last;

    // Requests waiting to be driven, and results predicted but not yet seen.
    table_req_t    pending_reqs[$];
    table_result_t expected_results[$];

    // Shadow copy of the slot table. Keys and handles are only ever read from
    // busy slots, so their power-up contents never matter.
    logic                       tbl_busy[SLOTS];
    logic [ksl_pkg::KEY_W-1:0]  tbl_key[SLOTS];
    logic [ksl_pkg::INFO_W-1:0] tbl_info[SLOTS];

    logic [ksl_pkg::KEY_W-1:0]  key_pool[POOL_SIZE];

    int reqs_issued = 0;   // requests raised on in_valid by the driver
    int reqs_taken  = 0;   // requests accepted by the block
    int mismatches  = 0;

    keyed_slot_table_unit #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .key          (key),
        .key_upper    (key_upper),
        .info_handle  (info_handle),
        .slot_index   (slot_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot         (slot),
        .found_key    (found_key),
        .found_info   (found_info),
        .removed_count(removed_count),
        .last         (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Applies one accepted request to the shadow table and queues the results
    // it must produce. A range select emits one result per matching busy slot
    // in slot order, capped at RESULT_LIMIT, else one no-match result; the held
    // match is released once the next is found, so only the final one carries last.
    function automatic void apply_table_op(input table_req_t r);
        logic [ksl_pkg::KEY_W-1:0]   lo;
        logic [ksl_pkg::KEY_W-1:0]   hi;
        int                          free_slot;
        int                          dup_slot;
        int                          n_match;
        logic [ksl_pkg::COUNT_W-1:0] n_removed;
        table_result_t               res;
        table_result_t               held;

        // Reversed bounds are swapped; insert uses the raw key below.
        lo = (r.key > r.key_upper) ? r.key_upper : r.key;
        hi = (r.key > r.key_upper) ? r.key : r.key_upper;
        res = '{status: ksl_pkg::ST_OK, slot: '0, found_key: '0, found_info: '0,
                removed_count: '0, last: 1'b1};
        held = res;
        case (r.func)
            ksl_pkg::FUNC_INSERT:
            begin
                free_slot = -1;
                dup_slot  = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (!tbl_busy[i])
                        free_slot = i;
                    if (tbl_busy[i] && tbl_key[i] == r.key)
                        dup_slot = i;
                end
                // A full table is reported before any duplicate.
                if (free_slot < 0)
                    res.status = ksl_pkg::ST_FULL;
                else if (dup_slot >= 0)
                begin
                    res.status = ksl_pkg::ST_DUPLICATE;
                    res.slot   = ksl_pkg::SLOT_W'(dup_slot);
                end
                else
                begin
                    tbl_busy[free_slot] = 1'b1;
                    tbl_key[free_slot]  = r.key;
                    tbl_info[free_slot] = r.info;
                    res.slot = ksl_pkg::SLOT_W'(free_slot);
                end
                expected_results.push_back(res);
            end
            ksl_pkg::FUNC_REMOVE, ksl_pkg::FUNC_READ:
            begin
                res.slot = r.index;
                if (r.index >= SLOTS)
                    res.status = ksl_pkg::ST_BAD_INDEX;
                else if (!tbl_busy[r.index])
                    res.status = ksl_pkg::ST_FREE;
                else if (r.func == ksl_pkg::FUNC_REMOVE)
                    tbl_busy[r.index] = 1'b0;
                else
                begin
                    res.found_key  = tbl_key[r.index];
                    res.found_info = tbl_info[r.index];
                end
                expected_results.push_back(res);
            end
            ksl_pkg::FUNC_DEL_RANGE:
            begin
                n_removed = '0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_busy[i] && tbl_key[i] >= lo && tbl_key[i] <= hi)
                    begin
                        tbl_busy[i] = 1'b0;
                        n_removed++;
                    end
                end
                res.status        = (n_removed != 0) ? ksl_pkg::ST_OK : ksl_pkg::ST_NO_MATCH;
                res.removed_count = n_removed;
                expected_results.push_back(res);
            end
            ksl_pkg::FUNC_SEL_RANGE:
            begin
                n_match = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (n_match < ksl_pkg::RESULT_LIMIT && tbl_busy[i] &&
                        tbl_key[i] >= lo && tbl_key[i] <= hi)
                    begin
                        if (n_match != 0)
                            expected_results.push_back(held);
                        held.slot       = ksl_pkg::SLOT_W'(i);
                        held.found_key  = tbl_key[i];
                        held.found_info = tbl_info[i];
                        held.last       = 1'b0;
                        n_match++;
                    end
                end
                if (n_match == 0)
                    res.status = ksl_pkg::ST_NO_MATCH;
                else
                    res = held;
                res.last = 1'b1;
                expected_results.push_back(res);
            end
            default:
            begin
                // Unknown codes are swallowed without a result.
            end
        endcase
    endfunction

    // Packs up to seven characters big-endian, zero padded on the right.
    function automatic logic [ksl_pkg::KEY_W-1:0] pack_name(input string s);
        logic [ksl_pkg::KEY_W-1:0] k;

        k = '0;
        for (int i = 0; i < s.len() && i < 7; i++)
            k = k | (ksl_pkg::KEY_W'(s[i]) << (8 * (6 - i)));
        return k;
    endfunction

    function automatic logic [ksl_pkg::KEY_W-1:0] rand_key();
        return ksl_pkg::KEY_W'({$urandom, $urandom});
    endfunction

    // Mostly keys from a small pool so that duplicates and range hits are
    // common, with fully random keys mixed in to toggle every bit.
    function automatic logic [ksl_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 65)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return rand_key();
    endfunction

    function automatic void add_req(input logic [ksl_pkg::FUNC_W-1:0] f,
                                    input logic [ksl_pkg::KEY_W-1:0] k,
                                    input logic [ksl_pkg::KEY_W-1:0] ku,
                                    input logic [ksl_pkg::INFO_W-1:0] inf,
                                    input logic [ksl_pkg::SLOT_W-1:0] idx);
        table_req_t r;

        r = '{func: f, key: k, key_upper: ku, info: inf, index: idx};
        pending_reqs.push_back(r);
    endfunction

    // Driver: presents the next request at the falling edge and holds it until
    // the monitor has seen it accepted. Both the request side and the result
    // side idle at random, except inside the calm window.
    always @(negedge clk)
    begin
        table_req_t next_req;
        logic       calm;

        calm = (reqs_taken >= CALM_FROM) && (reqs_taken < CALM_TO);
        if (rst_n)
        begin
            if (in_valid && reqs_taken != reqs_issued)
            begin
                // Still waiting for acceptance; the payload stays put.
            end
            else if (pending_reqs.size() != 0 &&
                     (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                next_req = pending_reqs.pop_front();
                in_valid    <= 1'b1;
                func        <= next_req.func;
                key         <= next_req.key;
                key_upper   <= next_req.key_upper;
                info_handle <= next_req.info;
                slot_index  <= next_req.index;
                reqs_issued <= reqs_issued + 1;
            end
            else
                in_valid <= 1'b0;
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Monitor: at the rising edge, an accepted request updates the shadow table
    // and queues its results; an accepted result is checked field by field
    // against the oldest queued one.
    always @(posedge clk)
    begin
        table_result_t got;
        table_result_t want;
        logic          bad;

        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                apply_table_op('{func: func, key: key, key_upper: key_upper,
                                 info: info_handle, index: slot_index});
                reqs_taken <= reqs_taken + 1;
            end
            if (out_valid && !out_stall)
            begin
                got = '{status: status, slot: slot, found_key: found_key,
                        found_info: found_info, removed_count: removed_count,
                        last: last};
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing expected: st=%0d slot=%0d",
                                 $realtime, got.status, got.slot);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad = (got.status !== want.status) || (got.slot !== want.slot) ||
                          (got.found_key !== want.found_key) ||
                          (got.found_info !== want.found_info) ||
                          (got.removed_count !== want.removed_count) ||
                          (got.last !== want.last);
                    if (bad)
                    begin
                        if (mismatches < 10)
                        begin
                            $display({"%0t: mismatch exp st=%0d slot=%0d key=%h",
                                      " info=%h cnt=%0d last=%b"},
                                     $realtime, want.status, want.slot, want.found_key,
                                     want.found_info, want.removed_count, want.last);
                            $display({"%0t:          got st=%0d slot=%0d key=%h",
                                      " info=%h cnt=%0d last=%b"},
                                     $realtime, got.status, got.slot, got.found_key,
                                     got.found_info, got.removed_count, got.last);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int                         n_total;
        int                         ins_pct;
        int                         pick;
        logic [ksl_pkg::FUNC_W-1:0] f;
        logic [ksl_pkg::KEY_W-1:0]  lo;
        logic [ksl_pkg::KEY_W-1:0]  hi;
        logic [ksl_pkg::SLOT_W-1:0] idx;
        string                      name;

        for (int i = 0; i < SLOTS; i++)
            tbl_busy[i] = 1'b0;

        // Key pool: the extremes plus short upper-case names.
        key_pool[0] = '0;
        key_pool[1] = ksl_pkg::KEY_W'(1);
        key_pool[2] = KEY_MAX;
        key_pool[3] = KEY_MAX - 1;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            name = "";
            repeat ($urandom_range(1, 7))
                name = {name, string'(8'($urandom_range(65, 90)))};
            key_pool[i] = pack_name(name);
        end

        // Directed part: empty-table reads and removes, bad indexes, ranges on
        // an empty table, extreme keys and handles, duplicates, lowest-free
        // placement after a removal, swapped bounds and unknown codes.
        add_req(ksl_pkg::FUNC_READ,      '0, '0, '0, '0);
        add_req(ksl_pkg::FUNC_REMOVE,    '0, '0, '0, '0);
        add_req(ksl_pkg::FUNC_READ,      '0, '0, '0, ksl_pkg::SLOT_W'(SLOTS));
        add_req(ksl_pkg::FUNC_REMOVE,    '0, '0, '0, '1);
        add_req(ksl_pkg::FUNC_SEL_RANGE, '0, KEY_MAX, '0, '0);
        add_req(ksl_pkg::FUNC_DEL_RANGE, KEY_MAX, '0, '0, '0);
        add_req(ksl_pkg::FUNC_INSERT,    '0, KEY_MAX, '0, '1);
        add_req(ksl_pkg::FUNC_INSERT,    KEY_MAX, '0, INFO_MAX, '0);
        add_req(ksl_pkg::FUNC_INSERT,    '0, '0, 32'h1234_5678, '0);
        add_req(ksl_pkg::FUNC_INSERT,    pack_name("ABC"), '0, $urandom, '0);
        add_req(ksl_pkg::FUNC_INSERT,    pack_name("ABCDEFG"), '0, $urandom, '0);
        add_req(ksl_pkg::FUNC_READ,      '0, '0, '0, 8'd1);
        add_req(ksl_pkg::FUNC_READ,      '0, '0, '0, ksl_pkg::SLOT_W'(SLOTS - 1));
        add_req(ksl_pkg::FUNC_SEL_RANGE, pack_name("ZZZ"), pack_name("A"), '0, '0);
        add_req(ksl_pkg::FUNC_SEL_RANGE, KEY_MAX, KEY_MAX, '0, '0);
        add_req(ksl_pkg::FUNC_REMOVE,    '0, '0, '0, 8'd0);
        add_req(ksl_pkg::FUNC_INSERT,    pack_name("ABC"), '0, $urandom, '0);
        add_req(ksl_pkg::FUNC_INSERT,    pack_name("A"), '0, $urandom, '0);
        add_req(ksl_pkg::FUNC_DEL_RANGE, pack_name("ABCDEFG"), pack_name("AB"), '0, '0);
        add_req(ksl_pkg::FUNC_READ,      '0, '0, '0, 8'd2);
        add_req(ksl_pkg::FUNC_READ + 3'd1, rand_key(), rand_key(), $urandom, 8'd0);
        add_req(ksl_pkg::FUNC_READ + 3'd2, rand_key(), rand_key(), $urandom, 8'd1);
        add_req(ksl_pkg::FUNC_READ + 3'd3, rand_key(), rand_key(), $urandom, 8'd2);
        add_req(ksl_pkg::FUNC_DEL_RANGE, '0, KEY_MAX, '0, '0);

        // Random part, in blocks. A fill burst drives the table to full and
        // then lists everything, so the full and sixteen-match cases recur.
        // Mixed blocks pick their own insert share so that occupancy wanders
        // between empty and full.
        while (pending_reqs.size() < TOTAL_ITEMS - 20)
        begin
            if ($urandom_range(3) == 0)
            begin
                repeat (18)
                    add_req(ksl_pkg::FUNC_INSERT, pick_key(), rand_key(), $urandom,
                            8'($urandom));
                lo = ($urandom_range(1) != 0) ? KEY_MAX : '0;
                add_req(ksl_pkg::FUNC_SEL_RANGE, lo, ~lo, $urandom, 8'($urandom));
                repeat ($urandom_range(2, 6))
                    add_req(($urandom_range(1) != 0) ? ksl_pkg::FUNC_READ
                                                     : ksl_pkg::FUNC_REMOVE,
                            rand_key(), rand_key(), $urandom,
                            8'($urandom_range(SLOTS - 1)));
            end
            else
            begin
                ins_pct = $urandom_range(15, 75);
                repeat (40)
                begin
                    lo  = pick_key();
                    hi  = pick_key();
                    idx = ($urandom_range(99) < 85) ? 8'($urandom_range(SLOTS - 1))
                                                    : 8'($urandom);
                    if ($urandom_range(99) < ins_pct)
                        f = ksl_pkg::FUNC_INSERT;
                    else
                    begin
                        pick = $urandom_range(99);
                        if (pick < 28)
                            f = ksl_pkg::FUNC_REMOVE;
                        else if (pick < 42)
                            f = ksl_pkg::FUNC_DEL_RANGE;
                        else if (pick < 68)
                            f = ksl_pkg::FUNC_SEL_RANGE;
                        else if (pick < 95)
                            f = ksl_pkg::FUNC_READ;
                        else
                            f = ksl_pkg::FUNC_READ + 3'($urandom_range(1, 3));
                    end
                    if (f == ksl_pkg::FUNC_SEL_RANGE && $urandom_range(9) == 0)
                    begin
                        lo = '0;
                        hi = KEY_MAX;
                    end
                    add_req(f, lo, hi, $urandom, idx);
                end
            end
        end
        n_total = pending_reqs.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (reqs_taken != n_total)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // Let any stray result from the last walk show up before deciding.
        repeat (4 * SLOTS) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("** keyed_slot_table_unit: PASSED **");
        else
            $display("** keyed_slot_table_unit: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial
    begin
        #1_000_000;
        $display("** keyed_slot_table_unit: FAILED **");
        $finish;
    end

endmodule
